// File: sv/qrv_pkg.sv
`timescale 1ns / 1ps
package qrv_pkg;

	// integer bits of the quaternion format (Q2.x)
	localparam int QUAT_INT_BITS = 2;

	// advance enables of the two register stages inside a split multiplier
	typedef struct packed {
		logic pp_en;
		logic sum_en;
	} qrv_adv_t;

endpackage

// File: sv/quat_rotate_vector.sv
`timescale 1ns / 1ps
// quaternion vector rotation, one item per clock unless the output stalls
//
// input channel: in_valid / in_ready carry an action bit, a quaternion
// (quat_x, quat_y, quat_z, quat_w, signed Q2.14) and a vector (vec_x, vec_y,
// vec_z, signed Q16.16). action 0 rotates by the quaternion, action 1 by its
// conjugate. no renormalization: a non-unit quaternion also scales the vector
// output channel: out_valid / out_ready carry out_x, out_y, out_z (rounded to
// nearest, ties upward, saturated) and saturated, set if any component clipped
// pipeline: six register stages, in order: pair products, rotation matrix,
// partial products, product sum, row sum with rounding, saturation into the
// output register
// throughput: one item per cycle unless stalled; the 9 matrix-by-vector
// multipliers each split in four partial products and set the pipeline depth
// reset: all stage valid bits clear, the block is empty and in_ready is high
// stall: when out_ready is low, stages fill up from the output back; in_ready
// drops only when all six stages hold an item, nothing is dropped or repeated
module quat_rotate_vector #(
	parameter int QUAT_WIDTH = 16,
	parameter int VEC_WIDTH  = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         action,
	input  logic signed [QUAT_WIDTH-1:0] quat_x,
	input  logic signed [QUAT_WIDTH-1:0] quat_y,
	input  logic signed [QUAT_WIDTH-1:0] quat_z,
	input  logic signed [QUAT_WIDTH-1:0] quat_w,
	input  logic signed [VEC_WIDTH-1:0]  vec_x,
	input  logic signed [VEC_WIDTH-1:0]  vec_y,
	input  logic signed [VEC_WIDTH-1:0]  vec_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [VEC_WIDTH-1:0]  out_x,
	output logic signed [VEC_WIDTH-1:0]  out_y,
	output logic signed [VEC_WIDTH-1:0]  out_z,
	output logic                         saturated
);
	import qrv_pkg::*;

	localparam int QP   = 2 * QUAT_WIDTH;          // pair product width
	localparam int MW   = QP + 2;                  // matrix entry width
	localparam int PW   = MW + VEC_WIDTH;          // matrix times vector
	localparam int AW   = PW + 3;                  // row sum with rounding
	localparam int DROP = 2 * (QUAT_WIDTH - QUAT_INT_BITS);

	localparam logic signed [VEC_WIDTH-1:0] VEC_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
	localparam logic signed [VEC_WIDTH-1:0] VEC_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};
	localparam logic signed [AW-1:0]        HALF    = AW'(1) <<< (DROP - 1);

	// stage valids and advance enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	assign adv6     = !valid_s6 || out_ready;
	assign adv5     = !valid_s5 || adv6;
	assign adv4     = !valid_s4 || adv5;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
			if (adv5) valid_s5 <= valid_s4;
			if (adv6) valid_s6 <= valid_s5;
		end
	end

	// stage 1: the ten quaternion pair products
	logic signed [QP-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [QP-1:0] xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic                 action_s1;
	logic signed [VEC_WIDTH-1:0] vec_s1 [3];

	always_ff @(posedge clk) begin
		if (adv1) begin
			ww_s1     <= quat_w * quat_w;
			xx_s1     <= quat_x * quat_x;
			yy_s1     <= quat_y * quat_y;
			zz_s1     <= quat_z * quat_z;
			xy_s1     <= quat_x * quat_y;
			xz_s1     <= quat_x * quat_z;
			yz_s1     <= quat_y * quat_z;
			wx_s1     <= quat_w * quat_x;
			wy_s1     <= quat_w * quat_y;
			wz_s1     <= quat_w * quat_z;
			action_s1 <= action;
			vec_s1[0] <= vec_x;
			vec_s1[1] <= vec_y;
			vec_s1[2] <= vec_z;
		end
	end

	// stage 2: rotation matrix; the conjugate flips the sign of the w-cross terms
	logic signed [MW-1:0] ww_e, xx_e, yy_e, zz_e, xy_e, xz_e, yz_e;
	logic signed [MW-1:0] wx_e, wy_e, wz_e;
	logic signed [MW-1:0] mat_d [9];
	logic signed [MW-1:0] mat_s2 [9];
	logic signed [VEC_WIDTH-1:0] vec_s2 [3];

	always_comb begin
		ww_e = MW'(ww_s1);
		xx_e = MW'(xx_s1);
		yy_e = MW'(yy_s1);
		zz_e = MW'(zz_s1);
		xy_e = MW'(xy_s1);
		xz_e = MW'(xz_s1);
		yz_e = MW'(yz_s1);
		wx_e = action_s1 ? -MW'(wx_s1) : MW'(wx_s1);
		wy_e = action_s1 ? -MW'(wy_s1) : MW'(wy_s1);
		wz_e = action_s1 ? -MW'(wz_s1) : MW'(wz_s1);
		mat_d[0] = ww_e + xx_e - yy_e - zz_e;
		mat_d[1] = (xy_e - wz_e) <<< 1;
		mat_d[2] = (xz_e + wy_e) <<< 1;
		mat_d[3] = (xy_e + wz_e) <<< 1;
		mat_d[4] = ww_e - xx_e + yy_e - zz_e;
		mat_d[5] = (yz_e - wx_e) <<< 1;
		mat_d[6] = (xz_e - wy_e) <<< 1;
		mat_d[7] = (yz_e + wx_e) <<< 1;
		mat_d[8] = ww_e - xx_e - yy_e + zz_e;
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			mat_s2 <= mat_d;
			vec_s2 <= vec_s1;
		end
	end

	// stages 3 and 4: matrix entry times vector component
	logic signed [PW-1:0] prod_s4 [9];
	qrv_adv_t             mul_adv;

	assign mul_adv = '{pp_en: adv3, sum_en: adv4};

	for (genvar i = 0; i < 9; i++) begin : g_mul
		qrv_mul #(
			.A_WIDTH(MW),
			.B_WIDTH(VEC_WIDTH)
		) u_mul (
			.clk (clk),
			.adv (mul_adv),
			.a   (mat_s2[i]),
			.b   (vec_s2[i % 3]),
			.prod(prod_s4[i])
		);
	end

	// stage 5: row sums plus the rounding half
	logic signed [AW-1:0] acc_s5 [3];

	always_ff @(posedge clk) begin
		if (adv5) begin
			for (int r = 0; r < 3; r++) begin
				acc_s5[r] <= AW'(prod_s4[3*r]) + AW'(prod_s4[3*r+1])
					+ AW'(prod_s4[3*r+2]) + HALF;
			end
		end
	end

	// stage 6: drop fraction bits, saturate, output register
	logic signed [VEC_WIDTH-1:0] res_d [3];
	logic [2:0]                  clip_d;
	logic signed [VEC_WIDTH-1:0] res_s6 [3];
	logic                        sat_s6;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			// bits above the result must all equal its sign
			clip_d[r] = !((&acc_s5[r][AW-1:DROP+VEC_WIDTH-1])
				|| !(|acc_s5[r][AW-1:DROP+VEC_WIDTH-1]));
			if (clip_d[r]) begin
				res_d[r] = acc_s5[r][AW-1] ? VEC_MIN : VEC_MAX;
			end else begin
				res_d[r] = acc_s5[r][DROP+VEC_WIDTH-1:DROP];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			res_s6 <= res_d;
			sat_s6 <= |clip_d;
		end
	end

	assign out_valid = valid_s6;
	assign out_x     = res_s6[0];
	assign out_y     = res_s6[1];
	assign out_z     = res_s6[2];
	assign saturated = sat_s6;

	// a set flag needs at least one component at a range limit
	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (out_x == VEC_MAX || out_x == VEC_MIN
			|| out_y == VEC_MAX || out_y == VEC_MIN
			|| out_z == VEC_MAX || out_z == VEC_MIN))
		else $error("saturated set with no component at a limit");

	// a stalled output freezes the row sums behind it
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && valid_s6 && !out_ready |=> valid_s5 && $stable(acc_s5[0])
			&& $stable(acc_s5[1]) && $stable(acc_s5[2]))
		else $error("row sum stage changed while stalled");

	// back pressure reaches the input only with every stage occupied
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && valid_s3 && valid_s4
			&& valid_s5 && valid_s6 && !out_ready)
		else $error("input stalled with a free stage");

endmodule

// File: sv/qrv_mul.sv
`timescale 1ns / 1ps
module qrv_mul #(
	parameter int A_WIDTH = 34,
	parameter int B_WIDTH = 32
) (
	input  logic                              clk,
	input  qrv_pkg::qrv_adv_t                 adv,
	input  logic signed [A_WIDTH-1:0]         a,
	input  logic signed [B_WIDTH-1:0]         b,
	output logic signed [A_WIDTH+B_WIDTH-1:0] prod
);
	import qrv_pkg::*;

	localparam int AL = A_WIDTH / 2;
	localparam int BL = B_WIDTH / 2;
	localparam int AH = A_WIDTH - AL;
	localparam int BH = B_WIDTH - BL;
	localparam int PW = A_WIDTH + B_WIDTH;

	// signed high parts, unsigned low parts
	logic signed [AH-1:0] a_hi;
	logic signed [BH-1:0] b_hi;
	logic signed [AL:0]   a_lo;
	logic signed [BL:0]   b_lo;

	logic signed [AH+BH-1:0] pp_hh_s1;
	logic signed [AH+BL:0]   pp_hl_s1;
	logic signed [AL+BH:0]   pp_lh_s1;
	logic signed [AL+BL+1:0] pp_ll_s1;

	assign a_hi = a[A_WIDTH-1:AL];
	assign b_hi = b[B_WIDTH-1:BL];
	assign a_lo = $signed({1'b0, a[AL-1:0]});
	assign b_lo = $signed({1'b0, b[BL-1:0]});

	always_ff @(posedge clk) begin
		if (adv.pp_en) begin
			pp_hh_s1 <= a_hi * b_hi;
			pp_hl_s1 <= a_hi * b_lo;
			pp_lh_s1 <= a_lo * b_hi;
			pp_ll_s1 <= a_lo * b_lo;
		end
	end

	// recombine the shifted partial products
	always_ff @(posedge clk) begin
		if (adv.sum_en) begin
			prod <= (PW'(pp_hh_s1) <<< (AL + BL))
				+ (PW'(pp_hl_s1) <<< AL)
				+ (PW'(pp_lh_s1) <<< BL)
				+ PW'(pp_ll_s1);
		end
	end

endmodule
